>>> rtl/cgns_pkg.sv
// Shared types, codes and constants for the cell grid neighbor search block.
package cgns_pkg;

   localparam int IDW = 12;         // atom index width
   localparam int PW = 24;          // coordinate width
   localparam int RW = 12;          // radius width
   localparam int PRW = 10;         // probe radius width
   localparam int CNW = 5;          // cells-per-axis register width
   localparam int STW = 3 * PW + RW;  // one stored atom: x, y, z, radius
   localparam int EDW = 12;         // cell edge width
   localparam int DIV_STEPS = PW;   // one quotient bit per cycle
   localparam int DCW = $clog2(DIV_STEPS);
   localparam int EDGE_BASE = 1536; // 6 angstrom
   localparam int THW = 14;         // r1 + r2 + 2*probe
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam int DEF_MAX_ATOMS = 4096;
   localparam int DEF_GRID_PER_AXIS = 16;
   localparam int DEF_CELL_SLOTS = 16;
   localparam int DEF_MAX_NEIGHBORS = 64;

   localparam logic [PRW-1:0] PROBE_RESET = 10'd358;
   localparam logic [CNW-1:0] CELLS_RESET = 5'd16;

   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [2:0] REG_PROBE = 3'd3;
   localparam logic [2:0] REG_CELLS_X = 3'd4;
   localparam logic [2:0] REG_CELLS_Y = 3'd5;
   localparam logic [2:0] REG_CELLS_Z = 3'd6;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_INSERT = 2'd1,
      OP_QUERY = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_DONE = 2'd0,
      KIND_NEIGHBOR = 2'd1,
      KIND_FULL = 2'd2,
      KIND_OUTSIDE = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [PW-1:0] origin_x;
      logic signed [PW-1:0] origin_y;
      logic signed [PW-1:0] origin_z;
      logic [PRW-1:0] probe;
      logic [CNW-1:0] cells_x;
      logic [CNW-1:0] cells_y;
      logic [CNW-1:0] cells_z;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic cap_a;
      logic cap_from_mem;
      logic store_wr;
      logic store_rd_a;
      logic div_start;
      logic fill_rd_ins;
      logic ins_commit;
      logic clr_init;
      logic clr_step;
      logic scan_init;
      logic fill_rd_scan;
      logic latch_fill;
      logic mem_rd;
      logic pos_rd;
      logic sq_calc;
      logic hit_take;
      logic hit_trunc;
      logic slot_next;
      logic cell_next;
      logic out_load;
      kind_type out_kind;
      logic out_pend;
      logic out_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic id_bad;
      logic div_busy;
      logic outside;
      logic fill_full;
      logic fill_zero;
      logic slot_last;
      logic cell_last;
      logic hit;
      logic cnt_full;
      logic pend_valid;
      logic out_free;
      logic clr_last;
   } sts_type;

endpackage

>>> rtl/cgns_axis_div.sv
// Three-lane restoring divider: offset / cell edge on each axis, one bit per cycle.
module cgns_axis_div
   import cgns_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [2:0][PW-1:0] dividend,
   input  logic [EDW-1:0] divisor,
   output logic busy,
   output logic [2:0][PW-1:0] quot
);

   logic busy_ff, busy_in;
   logic [DCW-1:0] step_ff, step_in;
   logic [EDW-1:0] dvs_ff, dvs_in;
   logic [2:0][PW-1:0] quo_ff, quo_in;
   logic [2:0][EDW:0] rem_ff, rem_in;
   logic [2:0][EDW:0] rem_sh;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int i = 0; i < 3; i++) begin
         rem_sh[i] = {rem_ff[i][EDW-1:0], quo_ff[i][PW-1]};
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvs_in = divisor;
         quo_in = dividend;
         rem_in = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            if (rem_sh[i] >= {1'b0, dvs_ff}) begin
               rem_in[i] = rem_sh[i] - {1'b0, dvs_ff};
               quo_in[i] = {quo_ff[i][PW-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_sh[i];
               quo_in[i] = {quo_ff[i][PW-2:0], 1'b0};
            end
         end
         step_in = step_ff + 1'b1;
         if (step_ff == DCW'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;

endmodule

>>> rtl/cgns_datapath.sv
// Datapath: atom store, cell tables, cell lookup, distance test, result register.
module cgns_datapath
   import cgns_pkg::*;
#(
   parameter int MAX_ATOMS = DEF_MAX_ATOMS,
   parameter int GRID_PER_AXIS = DEF_GRID_PER_AXIS,
   parameter int CELL_SLOTS = DEF_CELL_SLOTS,
   parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic [1:0] req_opcode,
   input  logic [IDW-1:0] req_atom_id,
   input  logic signed [PW-1:0] req_pos_x,
   input  logic signed [PW-1:0] req_pos_y,
   input  logic signed [PW-1:0] req_pos_z,
   input  logic [RW-1:0] req_atom_radius,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [IDW-1:0] rsp_neighbor_id,
   output logic signed [PW-1:0] rsp_neighbor_x,
   output logic signed [PW-1:0] rsp_neighbor_y,
   output logic signed [PW-1:0] rsp_neighbor_z,
   output logic [RW-1:0] rsp_neighbor_radius,
   output logic rsp_truncated,
   output logic rsp_last
);

   localparam int AW = $clog2(MAX_ATOMS);
   localparam int CW = $clog2(GRID_PER_AXIS);
   localparam int NCELLS = GRID_PER_AXIS * GRID_PER_AXIS * GRID_PER_AXIS;
   localparam int GG = GRID_PER_AXIS * GRID_PER_AXIS;
   localparam int CAW = $clog2(NCELLS);
   localparam int FW = $clog2(CELL_SLOTS + 1);
   localparam int NSLOT = NCELLS * CELL_SLOTS;
   localparam int MAW = $clog2(NSLOT);
   localparam int NBW = $clog2(MAX_NEIGHBORS + 1);
   localparam int GW = $clog2(GRID_PER_AXIS + 1);
   localparam int EW = (GW > CNW) ? GW : CNW;

   // latched request
   op_type op_ff;
   logic [IDW-1:0] id_ff;
   logic [STW-1:0] req_atom_ff;

   // atom under work (inserted or queried)
   logic signed [PW-1:0] ax_ff, ay_ff, az_ff;
   logic [RW-1:0] ar_ff;

   // memories
   logic [STW-1:0] st_mem [MAX_ATOMS];
   logic [STW-1:0] st_q_ff;
   logic [FW-1:0] fill_mem [NCELLS];
   logic [FW-1:0] fill_q_ff;
   logic [IDW-1:0] mbr_mem [NSLOT];
   logic [IDW-1:0] mbr_q_ff;

   // cell lookup
   logic div_busy;
   logic [2:0][PW-1:0] quot;
   logic [2:0][PW-1:0] dvd;
   logic [2:0] neg;
   logic [PW:0] dx_off, dy_off, dz_off;
   logic [EDW-1:0] edge_len;
   logic [2:0][EW-1:0] eff;
   logic [2:0][CW-1:0] ca, lo, hi, effm1;
   logic [2:0] over;
   logic [CAW-1:0] cell_a, cell_s;

   // scan
   logic [CW-1:0] sx_ff, sy_ff, sz_ff;
   logic [FW-1:0] nfill_ff, slot_ff;
   logic [CAW-1:0] clr_cnt_ff;
   logic [IDW-1:0] bid_ff;
   logic skip_ff;
   logic [2*PW-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [2*THW-1:0] thr2_ff;
   logic signed [PW:0] ddx, ddy, ddz;
   logic signed [2*PW+1:0] px2, py2, pz2;
   logic [THW-1:0] thr;
   logic [2*PW+1:0] d2;

   // pending neighbor, held back until the next one shows whether it is last
   logic pend_valid_ff;
   logic [IDW-1:0] pend_id_ff;
   logic [STW-1:0] pend_atom_ff;
   logic [NBW-1:0] cnt_ff;
   logic trunc_ff;

   // result register
   logic rsp_valid_ff;
   kind_type rsp_kind_ff;
   logic [IDW-1:0] rsp_id_ff;
   logic [STW-1:0] rsp_atom_ff;
   logic rsp_trunc_ff;
   logic rsp_last_ff;

   logic signed [PW-1:0] bx, by, bz;
   logic [RW-1:0] br;
   logic [AW-1:0] st_addr;
   logic [CAW-1:0] fill_addr;

   assign bx = st_q_ff[STW-1 -: PW];
   assign by = st_q_ff[STW-PW-1 -: PW];
   assign bz = st_q_ff[STW-2*PW-1 -: PW];
   assign br = st_q_ff[RW-1:0];

   // cell lookup: offset from origin, divided by the cell edge
   assign edge_len = EDW'({cfg.probe, 1'b0}) + EDW'(EDGE_BASE);
   assign dx_off = {ax_ff[PW-1], ax_ff} - {cfg.origin_x[PW-1], cfg.origin_x};
   assign dy_off = {ay_ff[PW-1], ay_ff} - {cfg.origin_y[PW-1], cfg.origin_y};
   assign dz_off = {az_ff[PW-1], az_ff} - {cfg.origin_z[PW-1], cfg.origin_z};
   assign neg = {dz_off[PW], dy_off[PW], dx_off[PW]};
   assign dvd[0] = dx_off[PW-1:0];
   assign dvd[1] = dy_off[PW-1:0];
   assign dvd[2] = dz_off[PW-1:0];

   cgns_axis_div u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .dividend(dvd),
      .divisor(edge_len),
      .busy(div_busy),
      .quot(quot)
   );

   always_comb begin
      logic [2:0][EW-1:0] n;
      n[0] = EW'(cfg.cells_x);
      n[1] = EW'(cfg.cells_y);
      n[2] = EW'(cfg.cells_z);
      for (int i = 0; i < 3; i++) begin
         if (n[i] == '0) begin
            eff[i] = EW'(1);
         end else if (n[i] > EW'(GRID_PER_AXIS)) begin
            eff[i] = EW'(GRID_PER_AXIS);
         end else begin
            eff[i] = n[i];
         end
         effm1[i] = CW'(eff[i] - 1'b1);
         over[i] = quot[i] >= PW'(eff[i]);
         ca[i] = quot[i][CW-1:0];
         lo[i] = (ca[i] == '0) ? '0 : ca[i] - 1'b1;
         hi[i] = (ca[i] < effm1[i]) ? ca[i] + 1'b1 : effm1[i];
      end
   end

   assign cell_a = CAW'(ca[0]) * CAW'(GG) + CAW'(ca[1]) * CAW'(GRID_PER_AXIS) + CAW'(ca[2]);
   assign cell_s = CAW'(sx_ff) * CAW'(GG) + CAW'(sy_ff) * CAW'(GRID_PER_AXIS) + CAW'(sz_ff);

   // distance test
   assign ddx = {bx[PW-1], bx} - {ax_ff[PW-1], ax_ff};
   assign ddy = {by[PW-1], by} - {ay_ff[PW-1], ay_ff};
   assign ddz = {bz[PW-1], bz} - {az_ff[PW-1], az_ff};
   assign px2 = ddx * ddx;
   assign py2 = ddy * ddy;
   assign pz2 = ddz * ddz;
   assign thr = THW'(ar_ff) + THW'(br) + THW'({cfg.probe, 1'b0});
   assign d2 = (2*PW+2)'(sqx_ff) + (2*PW+2)'(sqy_ff) + (2*PW+2)'(sqz_ff);

   assign st_addr = cmd.store_rd_a ? AW'(id_ff) : AW'(mbr_q_ff);
   assign fill_addr = cmd.fill_rd_ins ? cell_a : cell_s;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         st_mem[AW'(id_ff)] <= req_atom_ff;
      end
      if (cmd.store_rd_a || cmd.pos_rd) begin
         st_q_ff <= st_mem[st_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         fill_mem[clr_cnt_ff] <= '0;
      end else if (cmd.ins_commit) begin
         fill_mem[cell_a] <= fill_q_ff + 1'b1;
      end
      if (cmd.fill_rd_ins || cmd.fill_rd_scan) begin
         fill_q_ff <= fill_mem[fill_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_commit) begin
         mbr_mem[MAW'(cell_a) * MAW'(CELL_SLOTS) + MAW'(fill_q_ff)] <= id_ff;
      end
      if (cmd.mem_rd) begin
         mbr_q_ff <= mbr_mem[MAW'(cell_s) * MAW'(CELL_SLOTS) + MAW'(slot_ff)];
      end
   end

   // control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         pend_valid_ff <= 1'b0;
         cnt_ff <= '0;
         trunc_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_init) begin
            clr_cnt_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.scan_init) begin
            pend_valid_ff <= 1'b0;
            cnt_ff <= '0;
            trunc_ff <= 1'b0;
         end else begin
            if (cmd.hit_take) begin
               pend_valid_ff <= 1'b1;
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (cmd.hit_trunc) begin
               trunc_ff <= 1'b1;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= op_type'(req_opcode);
         id_ff <= req_atom_id;
         req_atom_ff <= {req_pos_x, req_pos_y, req_pos_z, req_atom_radius};
      end
      if (cmd.cap_a) begin
         if (cmd.cap_from_mem) begin
            {ax_ff, ay_ff, az_ff, ar_ff} <= st_q_ff;
         end else begin
            {ax_ff, ay_ff, az_ff, ar_ff} <= req_atom_ff;
         end
      end
      if (cmd.scan_init) begin
         sx_ff <= lo[0];
         sy_ff <= lo[1];
         sz_ff <= lo[2];
      end else if (cmd.cell_next) begin
         if (sz_ff != hi[2]) begin
            sz_ff <= sz_ff + 1'b1;
         end else begin
            sz_ff <= lo[2];
            if (sy_ff != hi[1]) begin
               sy_ff <= sy_ff + 1'b1;
            end else begin
               sy_ff <= lo[1];
               sx_ff <= sx_ff + 1'b1;
            end
         end
      end
      if (cmd.latch_fill) begin
         nfill_ff <= fill_q_ff;
         slot_ff <= '0;
      end else if (cmd.slot_next) begin
         slot_ff <= slot_ff + 1'b1;
      end
      if (cmd.pos_rd) begin
         bid_ff <= mbr_q_ff;
      end
      if (cmd.sq_calc) begin
         sqx_ff <= px2[2*PW-1:0];
         sqy_ff <= py2[2*PW-1:0];
         sqz_ff <= pz2[2*PW-1:0];
         thr2_ff <= (2*THW)'(thr) * (2*THW)'(thr);
         skip_ff <= (bid_ff == id_ff) || (32'(bid_ff) >= 32'(MAX_ATOMS));
      end
      if (cmd.hit_take) begin
         pend_id_ff <= bid_ff;
         pend_atom_ff <= st_q_ff;
      end
      if (cmd.out_load) begin
         rsp_kind_ff <= cmd.out_kind;
         rsp_last_ff <= cmd.out_last;
         if (cmd.out_pend) begin
            rsp_id_ff <= pend_id_ff;
            rsp_atom_ff <= pend_atom_ff;
            rsp_trunc_ff <= cmd.out_last & trunc_ff;
         end else begin
            rsp_id_ff <= '0;
            rsp_atom_ff <= '0;
            rsp_trunc_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.op = op_ff;
      sts.id_bad = 32'(id_ff) >= 32'(MAX_ATOMS);
      sts.div_busy = div_busy;
      sts.outside = (|neg) || (|over);
      sts.fill_full = fill_q_ff >= FW'(CELL_SLOTS);
      sts.fill_zero = fill_q_ff == '0;
      sts.slot_last = (slot_ff + 1'b1) == nfill_ff;
      sts.cell_last = (sx_ff == hi[0]) && (sy_ff == hi[1]) && (sz_ff == hi[2]);
      sts.hit = (d2 < (2*PW+2)'(thr2_ff)) && !skip_ff;
      sts.cnt_full = cnt_ff == NBW'(MAX_NEIGHBORS);
      sts.pend_valid = pend_valid_ff;
      sts.out_free = !rsp_valid_ff || !rsp_stall;
      sts.clr_last = clr_cnt_ff == CAW'(NCELLS - 1);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_neighbor_id = rsp_id_ff;
   assign rsp_neighbor_x = rsp_atom_ff[STW-1 -: PW];
   assign rsp_neighbor_y = rsp_atom_ff[STW-PW-1 -: PW];
   assign rsp_neighbor_z = rsp_atom_ff[STW-2*PW-1 -: PW];
   assign rsp_neighbor_radius = rsp_atom_ff[RW-1:0];
   assign rsp_truncated = rsp_trunc_ff;
   assign rsp_last = rsp_last_ff;

endmodule

>>> rtl/cgns_ctrl.sv
// Controller: sequences clear, insert and query over the datapath.
module cgns_ctrl
   import cgns_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_A,
      ST_DIV,
      ST_DIV_RUN,
      ST_INS_WAIT,
      ST_INS_CHK,
      ST_CLEAR,
      ST_Q_FILL,
      ST_Q_FILLD,
      ST_Q_MEM,
      ST_Q_MEMD,
      ST_Q_POS,
      ST_Q_SUM,
      ST_Q_NEXT,
      ST_Q_END,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   kind_type kind_ff, kind_in;
   logic pend_ff, pend_in;
   logic advance;

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      pend_in = pend_ff;
      cmd = '0;
      cmd.out_kind = KIND_DONE;
      advance = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_INIT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            pend_in = 1'b0;
            priority if (sts.op == OP_CLEAR) begin
               cmd.clr_init = 1'b1;
               state_in = ST_CLEAR;
            end else if (sts.op == OP_NOP) begin
               kind_in = KIND_DONE;
               state_in = ST_RESP;
            end else if (sts.id_bad) begin
               kind_in = KIND_OUTSIDE;
               state_in = ST_RESP;
            end else if (sts.op == OP_INSERT) begin
               cmd.store_wr = 1'b1;
               cmd.cap_a = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.store_rd_a = 1'b1;
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            cmd.cap_a = 1'b1;
            cmd.cap_from_mem = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (!sts.div_busy) begin
               priority if (sts.outside) begin
                  kind_in = KIND_OUTSIDE;
                  state_in = ST_RESP;
               end else if (sts.op == OP_INSERT) begin
                  cmd.fill_rd_ins = 1'b1;
                  state_in = ST_INS_WAIT;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in = ST_Q_FILL;
               end
            end
         end
         ST_INS_WAIT: begin
            state_in = ST_INS_CHK;
         end
         ST_INS_CHK: begin
            if (sts.fill_full) begin
               kind_in = KIND_FULL;
            end else begin
               cmd.ins_commit = 1'b1;
               kind_in = KIND_DONE;
            end
            state_in = ST_RESP;
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               kind_in = KIND_DONE;
               state_in = ST_RESP;
            end
         end
         ST_Q_FILL: begin
            cmd.fill_rd_scan = 1'b1;
            state_in = ST_Q_FILLD;
         end
         ST_Q_FILLD: begin
            cmd.latch_fill = 1'b1;
            state_in = sts.fill_zero ? ST_Q_NEXT : ST_Q_MEM;
         end
         ST_Q_MEM: begin
            cmd.mem_rd = 1'b1;
            state_in = ST_Q_MEMD;
         end
         ST_Q_MEMD: begin
            cmd.pos_rd = 1'b1;
            state_in = ST_Q_POS;
         end
         ST_Q_POS: begin
            cmd.sq_calc = 1'b1;
            state_in = ST_Q_SUM;
         end
         ST_Q_SUM: begin
            priority if (!sts.hit) begin
               advance = 1'b1;
            end else if (sts.cnt_full) begin
               cmd.hit_trunc = 1'b1;
               advance = 1'b1;
            end else if (!sts.pend_valid) begin
               cmd.hit_take = 1'b1;
               advance = 1'b1;
            end else if (sts.out_free) begin
               // older neighbor goes out, this one takes its place
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_NEIGHBOR;
               cmd.out_pend = 1'b1;
               cmd.hit_take = 1'b1;
               advance = 1'b1;
            end else begin
               advance = 1'b0;
            end
            if (advance) begin
               if (sts.slot_last) begin
                  state_in = ST_Q_NEXT;
               end else begin
                  cmd.slot_next = 1'b1;
                  state_in = ST_Q_MEM;
               end
            end
         end
         ST_Q_NEXT: begin
            if (sts.cell_last) begin
               state_in = ST_Q_END;
            end else begin
               cmd.cell_next = 1'b1;
               state_in = ST_Q_FILL;
            end
         end
         ST_Q_END: begin
            kind_in = sts.pend_valid ? KIND_NEIGHBOR : KIND_DONE;
            pend_in = sts.pend_valid;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = kind_ff;
               cmd.out_pend = pend_ff;
               cmd.out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         kind_ff <= KIND_DONE;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
         pend_ff <= pend_in;
      end
   end

endmodule

>>> rtl/cell_grid_neighbor_search.sv
// Top level: register port, controller and datapath of the grid neighbor search.
// Input channel req_*: one transaction is a clear, insert or query command.
// Result channel rsp_*: each command yields one or more result transactions;
// rsp_last marks the final one. A query gives one result per neighbor found
// (up to MAX_NEIGHBORS, rsp_truncated on the final one if more existed).
// Commands are taken one at a time; req_stall is low only while idle.
// Insert: the result waits on the cell divider.
// Query: a scan of up to 27 cells and of every filed slot in them; a result
// still waiting in the output register does not block the scan until the
// next neighbor has to go out.
// Clear: one cell count zeroed per cycle over all GRID_PER_AXIS**3 cells.
// After reset the same sweep runs with req_stall high; register writes are
// taken throughout. Registers reset to origin 0, probe 358, 16 cells per axis.
// A stalled result holds in the output register; the scan waits only when a
// further neighbor is found while it is still held. The user must write
// registers over the csr_ port only while no command is running; the block
// itself does not enforce this.
module cell_grid_neighbor_search
   import cgns_pkg::*;
#(
   parameter int MAX_ATOMS = DEF_MAX_ATOMS,
   parameter int GRID_PER_AXIS = DEF_GRID_PER_AXIS,
   parameter int CELL_SLOTS = DEF_CELL_SLOTS,
   parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_opcode,
   input  logic [IDW-1:0] req_atom_id,
   input  logic signed [PW-1:0] req_pos_x,
   input  logic signed [PW-1:0] req_pos_y,
   input  logic signed [PW-1:0] req_pos_z,
   input  logic [RW-1:0] req_atom_radius,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [IDW-1:0] rsp_neighbor_id,
   output logic signed [PW-1:0] rsp_neighbor_x,
   output logic signed [PW-1:0] rsp_neighbor_y,
   output logic signed [PW-1:0] rsp_neighbor_z,
   output logic [RW-1:0] rsp_neighbor_radius,
   output logic rsp_truncated,
   output logic rsp_last,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic csr_pready
);

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   logic csr_wr;
   logic [2:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
         cfg_ff.probe <= PROBE_RESET;
         cfg_ff.cells_x <= CELLS_RESET;
         cfg_ff.cells_y <= CELLS_RESET;
         cfg_ff.cells_z <= CELLS_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ORIGIN_X: cfg_ff.origin_x <= csr_pwdata[PW-1:0];
            REG_ORIGIN_Y: cfg_ff.origin_y <= csr_pwdata[PW-1:0];
            REG_ORIGIN_Z: cfg_ff.origin_z <= csr_pwdata[PW-1:0];
            REG_PROBE: cfg_ff.probe <= csr_pwdata[PRW-1:0];
            REG_CELLS_X: cfg_ff.cells_x <= csr_pwdata[CNW-1:0];
            REG_CELLS_Y: cfg_ff.cells_y <= csr_pwdata[CNW-1:0];
            REG_CELLS_Z: cfg_ff.cells_z <= csr_pwdata[CNW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ORIGIN_X: csr_prdata = {{(CSR_DW-PW){1'b0}}, cfg_ff.origin_x};
         REG_ORIGIN_Y: csr_prdata = {{(CSR_DW-PW){1'b0}}, cfg_ff.origin_y};
         REG_ORIGIN_Z: csr_prdata = {{(CSR_DW-PW){1'b0}}, cfg_ff.origin_z};
         REG_PROBE: csr_prdata = {{(CSR_DW-PRW){1'b0}}, cfg_ff.probe};
         REG_CELLS_X: csr_prdata = {{(CSR_DW-CNW){1'b0}}, cfg_ff.cells_x};
         REG_CELLS_Y: csr_prdata = {{(CSR_DW-CNW){1'b0}}, cfg_ff.cells_y};
         REG_CELLS_Z: csr_prdata = {{(CSR_DW-CNW){1'b0}}, cfg_ff.cells_z};
         default: csr_prdata = '0;
      endcase
   end

   cgns_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts(sts),
      .cmd(cmd)
   );

   cgns_datapath #(
      .MAX_ATOMS(MAX_ATOMS),
      .GRID_PER_AXIS(GRID_PER_AXIS),
      .CELL_SLOTS(CELL_SLOTS),
      .MAX_NEIGHBORS(MAX_NEIGHBORS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .cmd(cmd),
      .sts(sts),
      .req_opcode(req_opcode),
      .req_atom_id(req_atom_id),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_atom_radius(req_atom_radius),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_neighbor_id(rsp_neighbor_id),
      .rsp_neighbor_x(rsp_neighbor_x),
      .rsp_neighbor_y(rsp_neighbor_y),
      .rsp_neighbor_z(rsp_neighbor_z),
      .rsp_neighbor_radius(rsp_neighbor_radius),
      .rsp_truncated(rsp_truncated),
      .rsp_last(rsp_last)
   );

   // one command in flight: an accepted transaction closes the input
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a command is running");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_NEIGHBOR |-> rsp_last)
      else $error("status result not marked last");

   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_last && rsp_kind == KIND_NEIGHBOR)
      else $error("truncation mark off the final neighbor");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_NEIGHBOR |-> rsp_neighbor_id == '0
         && rsp_neighbor_radius == '0)
      else $error("status result carries neighbor data");

endmodule
